[hw/rtl/bps_pkg.sv]
// ----------------------------------------------------------------------------
// bps_pkg
// shared types and codes for the bucketed priority stack
// ----------------------------------------------------------------------------
package bps_pkg;

    // operation codes of an input beat
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    // result error codes
    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_LEVEL     = 2'd1,
        ERR_FULL      = 2'd2,
        ERR_POP_EMPTY = 2'd3
    } bps_err_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_POP_LINK,
        ST_LOAD_HEAD,
        ST_LOAD_VAL
    } bps_state_t;

    // register index of the limit on the configuration port
    localparam logic REG_PRIORITY_LIMIT = 1'b0;

    localparam int FIELD_LEVEL_W = 4;
    localparam logic [FIELD_LEVEL_W-1:0] LIMIT_RESET = 4'd15;

endpackage

[hw/rtl/bps_ram.sv]
// ----------------------------------------------------------------------------
// bps_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/bps_lvl_enc.sv]
// ----------------------------------------------------------------------------
// bps_lvl_enc
// finds the highest set bit of the level occupancy mask
// ----------------------------------------------------------------------------
module bps_lvl_enc #(
    parameter int LEVELS = 16
) (
    input  logic [LEVELS-1:0]                          mask,
    output logic                                       any,
    output logic [(LEVELS > 1 ? $clog2(LEVELS) : 1)-1:0] idx
);

    localparam int LVLW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (mask[i])
            begin
                idx = LVLW'(i);
            end
        end
    end

    assign any = |mask;

endmodule

[hw/rtl/bucketed_priority_stack.sv]
// ----------------------------------------------------------------------------
// bucketed_priority_stack
// priority stack with one lifo list per level, nodes held in a shared pool
// ----------------------------------------------------------------------------
//
// channel   direction  handshake               payload
// -------   ---------  ----------------------  ---------------------------------
// in        input      in_valid / in_stall     operation, element, level
// out       output     out_valid / out_stall   top_element, top_level, count,
//                                              is_empty, error
// cfg       input      apb (psel, penable)     priority_limit at byte address 0
//
// steps: peek, unused codes and rejected beats answer from idle, a push uses the
//   push state, a pop reads link then value while its level keeps elements, and
//   link, head and value through the synchronous rams when the level runs dry and
//   a lower level is left, but only the link when it empties the stack
// one beat is in flight at a time; the next is taken once the result leaves
// reset: occupancy, free list, counters and the output valid clear at once;
//   the rams need no clearing pass since every entry is written before it is read
// out_stall holds the result and, through in_stall, keeps the next beat out
//
module bucketed_priority_stack
    import bps_pkg::*;
#(
    parameter int LEVELS     = 16,
    parameter int POOL_DEPTH = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [31:0] element,
    input  logic [3:0]  level,

    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] top_element,
    output logic [3:0]  top_level,
    output logic [6:0]  count,
    output logic        is_empty,
    output logic [1:0]  error,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // level index, node index, link (node index plus the null marker), counters
    localparam int LVLW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTRW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int LINKW = $clog2(POOL_DEPTH + 1);
    localparam int CNTW  = $clog2(POOL_DEPTH + 1);
    localparam logic [LINKW-1:0] NULL_LINK = LINKW'(POOL_DEPTH);
    localparam logic [CNTW-1:0]  POOL_FULL = CNTW'(POOL_DEPTH);

    // control state
    bps_state_t              state_reg, state_next;
    logic [FIELD_LEVEL_W-1:0] limit_reg;
    logic [LEVELS-1:0]       nonempty_reg, nonempty_next;
    logic [LINKW-1:0]        free_head_reg, free_head_next;
    logic [CNTW-1:0]         fresh_reg, fresh_next;
    logic [CNTW-1:0]         stored_reg, stored_next;
    logic                    out_valid_reg, out_valid_next;

    // cached top of the stack and the beat being worked on
    logic [LVLW-1:0]         top_lvl_reg, top_lvl_next;
    logic [PTRW-1:0]         top_head_reg, top_head_next;
    logic [ELEM_WIDTH-1:0]   top_elem_reg, top_elem_next;
    logic [ELEM_WIDTH-1:0]   item_elem_reg, item_elem_next;
    logic [LVLW-1:0]         item_lvl_reg, item_lvl_next;
    bps_err_t                res_err_reg, res_err_next;

    // ram ports
    logic                    heads_we;
    logic [LVLW-1:0]         heads_waddr, heads_raddr;
    logic [PTRW-1:0]         heads_wdata, heads_rdata;
    logic                    values_we;
    logic [PTRW-1:0]         values_waddr, values_raddr;
    logic [ELEM_WIDTH-1:0]   values_wdata, values_rdata;
    logic                    links_we;
    logic [PTRW-1:0]         links_waddr, links_raddr;
    logic [LINKW-1:0]        links_wdata, links_rdata;

    // helpers
    logic                    in_fire, out_fire, cfg_write;
    logic                    free_valid, lvl_bad;
    logic [PTRW-1:0]         alloc_node;
    logic [LEVELS-1:0]       cleared_mask;
    logic                    cleared_any;
    logic [LVLW-1:0]         cleared_top;

    // ---------------------------------------------------------------- storage
    // head node of each level
    bps_ram #(.WIDTH(PTRW), .DEPTH(LEVELS)) u_heads (
        .clk   (clk),
        .we    (heads_we),
        .waddr (heads_waddr),
        .wdata (heads_wdata),
        .raddr (heads_raddr),
        .rdata (heads_rdata)
    );

    // element value of each node
    bps_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(POOL_DEPTH)) u_values (
        .clk   (clk),
        .we    (values_we),
        .waddr (values_waddr),
        .wdata (values_wdata),
        .raddr (values_raddr),
        .rdata (values_rdata)
    );

    // next node of each node, shared by the level lists and the free list
    bps_ram #(.WIDTH(LINKW), .DEPTH(POOL_DEPTH)) u_links (
        .clk   (clk),
        .we    (links_we),
        .waddr (links_waddr),
        .wdata (links_wdata),
        .raddr (links_raddr),
        .rdata (links_rdata)
    );

    // occupancy with the popped level removed, for the top after a list runs dry
    assign cleared_mask = nonempty_reg & ~(LEVELS'(1) << top_lvl_reg);

    bps_lvl_enc #(.LEVELS(LEVELS)) u_lvl_enc (
        .mask (cleared_mask),
        .any  (cleared_any),
        .idx  (cleared_top)
    );

    // ---------------------------------------------------------------- handshakes
    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign cfg_write = psel && penable && pwrite && pready;

    // free list first, then the never-used part of the pool
    assign free_valid = (free_head_reg != NULL_LINK);
    assign alloc_node = free_valid ? free_head_reg[PTRW-1:0] : fresh_reg[PTRW-1:0];
    assign lvl_bad    = (level > limit_reg) || (int'(level) >= LEVELS);

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next     = state_reg;
        nonempty_next  = nonempty_reg;
        free_head_next = free_head_reg;
        fresh_next     = fresh_reg;
        stored_next    = stored_reg;
        out_valid_next = out_valid_reg;
        top_lvl_next   = top_lvl_reg;
        top_head_next  = top_head_reg;
        top_elem_next  = top_elem_reg;
        item_elem_next = item_elem_reg;
        item_lvl_next  = item_lvl_reg;
        res_err_next   = res_err_reg;

        heads_we     = 1'b0;
        heads_waddr  = item_lvl_reg;
        heads_wdata  = alloc_node;
        heads_raddr  = LVLW'(level);
        values_we    = 1'b0;
        values_waddr = alloc_node;
        values_wdata = item_elem_reg;
        values_raddr = links_rdata[PTRW-1:0];
        links_we     = 1'b0;
        links_waddr  = alloc_node;
        links_wdata  = NULL_LINK;
        links_raddr  = free_head_reg[PTRW-1:0];

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    item_elem_next = ELEM_WIDTH'(element);
                    item_lvl_next  = LVLW'(level);
                    unique case (operation)
                        OP_PUSH:
                        begin
                            if (lvl_bad)
                            begin
                                res_err_next   = ERR_LEVEL;
                                out_valid_next = 1'b1;
                            end
                            else if (stored_reg >= POOL_FULL)
                            begin
                                res_err_next   = ERR_FULL;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                // old head of the level and the next free node
                                heads_raddr = LVLW'(level);
                                links_raddr = free_head_reg[PTRW-1:0];
                                state_next  = ST_PUSH;
                            end
                        end
                        OP_POP:
                        begin
                            if (stored_reg == '0)
                            begin
                                res_err_next   = ERR_POP_EMPTY;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                links_raddr = top_head_reg;
                                state_next  = ST_POP_LINK;
                            end
                        end
                        default:
                        begin
                            // peek and the unused code only report
                            res_err_next   = ERR_OK;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_PUSH:
            begin
                values_we    = 1'b1;
                values_waddr = alloc_node;
                values_wdata = item_elem_reg;
                links_we     = 1'b1;
                links_waddr  = alloc_node;
                links_wdata  = nonempty_reg[item_lvl_reg] ? LINKW'(heads_rdata) : NULL_LINK;
                heads_we     = 1'b1;
                heads_waddr  = item_lvl_reg;
                heads_wdata  = alloc_node;
                if (free_valid)
                begin
                    free_head_next = links_rdata;
                end
                else
                begin
                    fresh_next = fresh_reg + CNTW'(1);
                end
                nonempty_next[item_lvl_reg] = 1'b1;
                stored_next = stored_reg + CNTW'(1);
                if ((nonempty_reg == '0) || (item_lvl_reg >= top_lvl_reg))
                begin
                    top_lvl_next  = item_lvl_reg;
                    top_head_next = alloc_node;
                    top_elem_next = item_elem_reg;
                end
                res_err_next   = ERR_OK;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end

            ST_POP_LINK:
            begin
                // popped node goes to the head of the free list
                links_we       = 1'b1;
                links_waddr    = top_head_reg;
                links_wdata    = free_head_reg;
                free_head_next = LINKW'(top_head_reg);
                stored_next    = stored_reg - CNTW'(1);
                if (links_rdata != NULL_LINK)
                begin
                    heads_we      = 1'b1;
                    heads_waddr   = top_lvl_reg;
                    heads_wdata   = links_rdata[PTRW-1:0];
                    top_head_next = links_rdata[PTRW-1:0];
                    values_raddr  = links_rdata[PTRW-1:0];
                    state_next    = ST_LOAD_VAL;
                end
                else
                begin
                    nonempty_next = cleared_mask;
                    if (cleared_any)
                    begin
                        top_lvl_next = cleared_top;
                        heads_raddr  = cleared_top;
                        state_next   = ST_LOAD_HEAD;
                    end
                    else
                    begin
                        top_lvl_next   = '0;
                        res_err_next   = ERR_OK;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end

            ST_LOAD_HEAD:
            begin
                top_head_next = heads_rdata;
                values_raddr  = heads_rdata;
                state_next    = ST_LOAD_VAL;
            end

            ST_LOAD_VAL:
            begin
                top_elem_next  = values_rdata;
                res_err_next   = ERR_OK;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= LIMIT_RESET;
            nonempty_reg  <= '0;
            free_head_reg <= NULL_LINK;
            fresh_reg     <= '0;
            stored_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nonempty_reg  <= nonempty_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            stored_reg    <= stored_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && (paddr[2] == REG_PRIORITY_LIMIT))
            begin
                limit_reg <= pwdata[FIELD_LEVEL_W-1:0];
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        top_lvl_reg   <= top_lvl_next;
        top_head_reg  <= top_head_next;
        top_elem_reg  <= top_elem_next;
        item_elem_reg <= item_elem_next;
        item_lvl_reg  <= item_lvl_next;
        res_err_reg   <= res_err_next;
    end

    // ---------------------------------------------------------------- outputs
    // state only moves while a beat is in flight, so the result holds under stall
    assign out_valid   = out_valid_reg;
    assign top_element = (stored_reg == '0) ? '0 : 32'(top_elem_reg);
    assign top_level   = (stored_reg == '0) ? '0 : 4'(top_lvl_reg);
    assign count       = 7'(stored_reg);
    assign is_empty    = (stored_reg == '0);
    assign error       = res_err_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PRIORITY_LIMIT) ? 32'(limit_reg) : '0;

endmodule

[sim/bps_result_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bps_result_check
// watches the beat channels and the register port of the bucketed priority
// stack, keeps its own copy of the stack and compares every result beat
// ----------------------------------------------------------------------------
module bps_result_check
    import bps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [31:0] element,
    input  logic [3:0]  level,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] top_element,
    input  logic [3:0]  top_level,
    input  logic [6:0]  count,
    input  logic        is_empty,
    input  logic [1:0]  error,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,

    output int          fail_count,
    output int          pending
);

    localparam int         NUM_LEVELS = 16;
    localparam int         NODE_COUNT = 64;
    localparam logic [6:0] NO_NODE    = 7'd64;
    localparam logic [2:0] LIMIT_ADDR = {REG_PRIORITY_LIMIT, 2'b00};

    typedef struct packed {
        logic [31:0] top_element;
        logic [3:0]  top_level;
        logic [6:0]  count;
        logic        is_empty;
        bps_err_t    error;
    } stack_result_t;

    // shadow of the stack
    logic [5:0]            level_head [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] level_used;
    logic [31:0]           node_elem  [NODE_COUNT];
    logic [6:0]            node_next  [NODE_COUNT];
    logic [6:0]            free_top;
    logic [6:0]            fresh_used;
    logic [6:0]            stored;
    logic [3:0]            limit_q;

    stack_result_t expected_q [$];
    stack_result_t predicted;
    stack_result_t oldest;
    int            fails;

    task automatic report_fail(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fails++;
    endtask

    // highest level holding elements, -1 when all are empty
    function automatic int highest_used();
        int lv;
        for (lv = NUM_LEVELS - 1; lv >= 0; lv--)
        begin
            if (level_used[lv])
                return lv;
        end
        return -1;
    endfunction

    task automatic apply_beat(input logic [1:0] op, input logic [31:0] elem,
                              input logic [3:0] lvl, output stack_result_t res);
        int         top;
        logic [6:0] n;
        logic [6:0] nxt;
        logic [5:0] h;
        res.error = ERR_OK;
        if (op == OP_PUSH)
        begin
            if (lvl > limit_q)
                res.error = ERR_LEVEL;
            else if (stored >= NODE_COUNT)
                res.error = ERR_FULL;
            else
            begin
                if (free_top != NO_NODE)
                begin
                    n        = free_top;
                    free_top = node_next[n[5:0]];
                end
                else
                begin
                    n          = fresh_used;
                    fresh_used = fresh_used + 7'd1;
                end
                node_elem[n[5:0]] = elem;
                node_next[n[5:0]] = level_used[lvl] ? {1'b0, level_head[lvl]} : NO_NODE;
                level_head[lvl]   = n[5:0];
                level_used[lvl]   = 1'b1;
                stored            = stored + 7'd1;
            end
        end
        else if (op == OP_POP)
        begin
            top = highest_used();
            if (top < 0)
                res.error = ERR_POP_EMPTY;
            else
            begin
                h   = level_head[top];
                nxt = node_next[h];
                if (nxt != NO_NODE)
                    level_head[top] = nxt[5:0];
                else
                    level_used[top] = 1'b0;
                node_next[h] = free_top;
                free_top     = {1'b0, h};
                stored       = stored - 7'd1;
            end
        end
        top = highest_used();
        if (top >= 0)
        begin
            res.top_element = node_elem[level_head[top]];
            res.top_level   = 4'(top);
        end
        else
        begin
            res.top_element = '0;
            res.top_level   = '0;
        end
        res.count    = stored;
        res.is_empty = (stored == 7'd0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_used = '0;
            free_top   = NO_NODE;
            fresh_used = '0;
            stored     = '0;
            limit_q    = LIMIT_RESET;
            fails      = 0;
            expected_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
                limit_q = pwdata[3:0];
            if (in_valid && !in_stall)
            begin
                apply_beat(operation, element, level, predicted);
                expected_q.push_back(predicted);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                    report_fail("result beat with no expectation waiting");
                else
                begin
                    oldest = expected_q.pop_front();
                    if (top_element !== oldest.top_element)
                        report_fail($sformatf("top_element got %0h expected %0h",
                                              top_element, oldest.top_element));
                    if (top_level !== oldest.top_level)
                        report_fail($sformatf("top_level got %0d expected %0d",
                                              top_level, oldest.top_level));
                    if (count !== oldest.count)
                        report_fail($sformatf("count got %0d expected %0d",
                                              count, oldest.count));
                    if (is_empty !== oldest.is_empty)
                        report_fail($sformatf("is_empty got %0b expected %0b",
                                              is_empty, oldest.is_empty));
                    if (error !== oldest.error)
                        report_fail($sformatf("error got %0d expected %0d",
                                              error, oldest.error));
                end
            end
        end
        pending    = expected_q.size();
        fail_count = fails;
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the bucketed priority stack: directed pushes and pops over the
// level and pool corner cases, then random phases under several limits with
// bursty input, a stalling receiver and one long receiver hold-off
// ----------------------------------------------------------------------------
module tb;
    import bps_pkg::*;

    // code the block treats like a peek
    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam logic [2:0] LIMIT_ADDR  = {REG_PRIORITY_LIMIT, 2'b00};
    // long receiver hold-off, in cycles
    localparam int HOLD_CYCLES = 400;
    // idle cycles after the last result, well past the longest pop
    localparam int SETTLE_CYCLES = 10;

    logic        clk;
    logic        rst_n     = 1'b0;

    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = OP_PEEK;
    logic [31:0] element   = '0;
    logic [3:0]  level     = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] top_element;
    logic [3:0]  top_level;
    logic [6:0]  count;
    logic        is_empty;
    logic [1:0]  error;

    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;

    // set by the stimulus, cleared by the receiver once the hold-off is over
    logic        hold_req  = 1'b0;
    int          burst_left = 1;
    int          cur_limit  = 15;

    bucketed_priority_stack dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .element     (element),
        .level       (level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .top_element (top_element),
        .top_level   (top_level),
        .count       (count),
        .is_empty    (is_empty),
        .error       (error),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // prediction and comparison live beside the block
    bps_result_check result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .element     (element),
        .level       (level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .top_element (top_element),
        .top_level   (top_level),
        .count       (count),
        .is_empty    (is_empty),
        .error       (error),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard limit on the whole run
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: stall pattern changes after each random-length segment, and once the
    // stimulus asks it holds off long enough to back the block up
    // ------------------------------------------------------------------------
    initial
    begin
        int mode;
        int seg;
        int tick;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(10, 60);
            repeat (seg)
            begin
                @(negedge clk);
                if (hold_req)
                begin
                    // long hold-off while the sender keeps offering beats
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_req = 1'b0;
                end
                tick++;
                case (mode)
                    0: out_stall <= 1'b0;                        // no stalls
                    1: out_stall <= 1'($urandom_range(0, 1));     // coin flip
                    2: out_stall <= (tick % 4 == 0);              // periodic
                    default: out_stall <= ($urandom_range(0, 9) < 8); // mostly held
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender helpers; every task is entered and left at a falling edge
    // ------------------------------------------------------------------------

    // offer one beat and hold it until the block takes it
    task automatic send_beat(input logic [1:0] op, input logic [31:0] elem,
                             input logic [3:0] lvl);
        in_valid  <= 1'b1;
        operation <= op;
        element   <= elem;
        level     <= lvl;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // wait until every predicted result has come back
    task automatic wait_results();
        while (pending != 0)
            @(negedge clk);
    endtask

    // burst pacing after each beat: random gap, or a full pause until drained
    task automatic offer(input logic [1:0] op, input logic [31:0] elem,
                         input logic [3:0] lvl);
        int gap;
        send_beat(op, elem, lvl);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 16);
            if ($urandom_range(0, 7) == 0)
            begin
                // sender goes quiet until the block has answered everything
                in_valid <= 1'b0;
                @(negedge clk);
                wait_results();
            end
            else
            begin
                gap = $urandom_range(0, 6);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
    endtask

    // register write, only once the block has gone idle
    task automatic write_limit(input logic [3:0] value);
        in_valid <= 1'b0;
        @(negedge clk);
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        // setup phase, junk in the upper data bits
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= {28'($urandom()), value};
        @(negedge clk);
        // access phase
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        cur_limit  = value;
        @(negedge clk);
    endtask

    // one random phase: limit, length and operation mix
    task automatic run_phase(input logic [3:0] limit, input int items,
                             input int push_pct, input int pop_pct, input bit hold);
        int          pick;
        logic [1:0]  op;
        logic [31:0] elem;
        logic [3:0]  lvl;
        write_limit(limit);
        if (hold)
            hold_req = 1'b1;
        repeat (items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < push_pct)
                op = OP_PUSH;
            else if (pick < push_pct + pop_pct)
                op = OP_POP;
            else
                op = ($urandom_range(0, 3) == 0) ? OP_RESERVED : OP_PEEK;
            // element extremes now and then
            case ($urandom_range(0, 9))
                0: elem = '0;
                1: elem = '1;
                default: elem = $urandom();
            endcase
            // mostly legal levels, some above the limit
            if ($urandom_range(0, 7) == 0)
                lvl = 4'($urandom_range(0, 15));
            else
                lvl = 4'($urandom_range(0, cur_limit));
            offer(op, elem, lvl);
        end
    endtask

    // ------------------------------------------------------------------------
    // main stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty stack: peek, pop when empty, unused code
        offer(OP_PEEK, 32'h1234_5678, 4'd3);
        offer(OP_POP, '0, '0);
        offer(OP_RESERVED, '1, '1);
        // extremes of element and level, two on one level
        offer(OP_PUSH, 32'hFFFF_FFFF, 4'd15);
        offer(OP_PUSH, 32'h0000_0000, 4'd0);
        offer(OP_PUSH, 32'hA5A5_5A5A, 4'd0);
        offer(OP_PUSH, 32'h0000_0001, 4'd7);
        offer(OP_PEEK, '0, '0);
        // level runs dry, then a level that keeps an element
        offer(OP_POP, '0, '0);
        offer(OP_POP, '0, '0);
        offer(OP_POP, '0, '0);
        // freed node reused
        offer(OP_PUSH, 32'h8000_0000, 4'd0);
        offer(OP_RESERVED, 32'h5555_AAAA, 4'd9);
        offer(OP_POP, '0, '0);
        offer(OP_POP, '0, '0);
        offer(OP_POP, '0, '0);

        // lowest limit: anything above level zero is refused
        write_limit(4'd0);
        offer(OP_PUSH, 32'hDEAD_BEEF, 4'd1);
        offer(OP_PUSH, 32'hDEAD_BEEF, 4'd15);
        offer(OP_PUSH, 32'h0BAD_F00D, 4'd0);
        offer(OP_POP, '0, '0);

        // limit lowered after pushes: stored high levels stay visible
        write_limit(4'd15);
        offer(OP_PUSH, 32'h0000_00C0, 4'd12);
        offer(OP_PUSH, 32'h0000_0090, 4'd9);
        write_limit(4'd4);
        offer(OP_PUSH, 32'h0000_0050, 4'd5);
        offer(OP_PEEK, '0, '0);
        offer(OP_POP, '0, '0);
        offer(OP_POP, '0, '0);
        offer(OP_POP, '0, '0);

        // random phases: fill to pool full, mixed under a low limit,
        // drain, a phase with the long receiver hold-off, and a balanced tail
        run_phase(4'd15, 150, 85, 10, 1'b0);
        run_phase(4'd3, 100, 40, 40, 1'b0);
        run_phase(4'd0, 110, 15, 75, 1'b0);
        run_phase(4'($urandom_range(1, 14)), 120, 50, 35, 1'b1);
        run_phase(4'd15, 120, 55, 35, 1'b0);

        // drain and let the block settle
        in_valid <= 1'b0;
        @(negedge clk);
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
